FILE: rtl/cdate_pkg.sv
package cdate_pkg;

  // field widths
  localparam int FUNC_W      = 2;
  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  localparam int COUNT_W     = 16;
  localparam int Y400_W      = 9;
  localparam int Q400_W      = 6;
  localparam int PROD_W      = 28;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;
  localparam int RES_W       = 25;

  // operation codes carried on in_tuser
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FWD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BACK = 2'd2;

  // calendar constants
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_28    = 5'd28;
  localparam logic [DAY_W-1:0]   DAY_29    = 5'd29;
  localparam logic [DAY_W-1:0]   DAY_30    = 5'd30;
  localparam logic [DAY_W-1:0]   DAY_31    = 5'd31;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_RESET = 14'd1900;
  localparam logic [YEAR_W-1:0]  YEAR_ZERO  = 14'd0;

  // year modulo 400 bookkeeping
  localparam logic [Y400_W-1:0] YEARS_400  = 9'd400;
  localparam logic [Y400_W-1:0] Y400_TOP   = 9'd399;
  localparam logic [Y400_W-1:0] Y400_100   = 9'd100;
  localparam logic [Y400_W-1:0] Y400_200   = 9'd200;
  localparam logic [Y400_W-1:0] Y400_300   = 9'd300;
  localparam logic [Y400_W-1:0] Y400_RESET = Y400_W'(1900 % 400);

  // reciprocal of 400 scaled by 2^22, for the load-time remainder
  localparam logic [YEAR_W-1:0] RECIP_400   = 14'd10485;
  localparam int                RECIP_SHIFT = 22;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_Q,
    ST_LOAD_FIX,
    ST_STEP,
    ST_OUT
  } cdate_state_t;

  typedef struct packed {
    logic capture;
    logic load_q;
    logic load_fix;
    logic step;
    logic back;
    logic set_err;
    logic out_load;
  } cdate_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic at_bound;
  } cdate_sts_t;

  // leap year from the year modulo 400
  function automatic logic leap_of(input logic [Y400_W-1:0] y400);
    leap_of = (y400[1:0] == 2'b00) &&
              !((y400 == Y400_100) || (y400 == Y400_200) || (y400 == Y400_300));
  endfunction

  // length of a month in days
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = DAY_31;
    case (m)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_30;
      MONTH_FEB: len = leap ? DAY_29 : DAY_28;
      default: len = DAY_31;
    endcase
    month_len = len;
  endfunction

endpackage

FILE: rtl/cdate_ctrl.sv
module cdate_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [cdate_pkg::FUNC_W-1:0] in_func,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output cdate_pkg::cdate_cmd_t      cmd,
  input  cdate_pkg::cdate_sts_t      sts
);
  import cdate_pkg::*;

  cdate_state_t state_r, state_nxt;
  logic         back_r, back_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_func)
            FUNC_LOAD:           state_nxt = ST_LOAD_Q;
            FUNC_FWD, FUNC_BACK: state_nxt = ST_STEP;
            default:             state_nxt = ST_OUT;
          endcase
        end
      end
      ST_LOAD_Q:   state_nxt = ST_LOAD_FIX;
      ST_LOAD_FIX: state_nxt = ST_OUT;
      ST_STEP: begin
        if (sts.cnt_zero || sts.at_bound) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    cmd.back = back_r;
    case (state_r)
      ST_IDLE:     cmd.capture  = in_tvalid;
      ST_LOAD_Q:   cmd.load_q   = 1'b1;
      ST_LOAD_FIX: cmd.load_fix = 1'b1;
      ST_STEP: begin
        if (!sts.cnt_zero) begin
          if (sts.at_bound) cmd.set_err = 1'b1;
          else              cmd.step    = 1'b1;
        end
      end
      ST_OUT:      cmd.out_load = out_free;
      default:     cmd          = '0;
    endcase
  end

  // direction and result valid
  always_comb begin
    back_nxt = back_r;
    if (cmd.capture) back_nxt = (in_func == FUNC_BACK);
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_tready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      back_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      back_r      <= back_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && sts.cnt_zero) |=> (state_r == ST_OUT))
    else $error("step loop did not end at zero count");

  a_step_safe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!sts.at_bound && !sts.cnt_zero))
    else $error("step issued at bound or with no days left");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !cmd.out_load)
    else $error("result register overwritten while stalled");

  a_load_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD_Q) |=> (state_r == ST_LOAD_FIX) ##1 (state_r == ST_OUT))
    else $error("load sequence broken");

endmodule

FILE: rtl/cdate_dp.sv
module cdate_dp #(
  parameter int COUNT_BITS = 16,
  parameter int YEAR_MAX   = 9999
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cdate_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic [cdate_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  cdate_pkg::cdate_cmd_t             cmd,
  output cdate_pkg::cdate_sts_t             sts
);
  import cdate_pkg::*;

  localparam int CNT_W = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
  localparam logic [YEAR_W-1:0] YEAR_LIM = YEAR_W'(YEAR_MAX);

  // unpack the input transaction
  logic [DAY_W-1:0]   in_day;
  logic [MONTH_W-1:0] in_month;
  logic [YEAR_W-1:0]  in_year;
  logic [COUNT_W-1:0] in_count;
  assign in_day   = in_tdata[4:0];
  assign in_month = in_tdata[8:5];
  assign in_year  = in_tdata[22:9];
  assign in_count = in_tdata[38:23];

  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [Y400_W-1:0]  y400_r, y400_nxt;
  logic               err_r, err_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DAY_W-1:0]   ld_day_r, ld_day_nxt;
  logic [MONTH_W-1:0] ld_month_r, ld_month_nxt;
  logic [YEAR_W-1:0]  ld_year_r, ld_year_nxt;
  logic [Q400_W-1:0]  q_r, q_nxt;
  logic [RES_W-1:0]   res_r, res_nxt;

  logic               leap_cur;
  logic [DAY_W-1:0]   len_cur, len_prev;
  logic [MONTH_W-1:0] month_prev;
  logic [PROD_W-1:0]  prod;
  logic [YEAR_W-1:0]  rem_raw;
  logic [Y400_W-1:0]  rem;
  logic [DAY_W-1:0]   ld_len;

  assign leap_cur   = leap_of(y400_r);
  assign len_cur    = month_len(month_r, leap_cur);
  assign month_prev = month_r - MONTH_JAN;
  assign len_prev   = month_len(month_prev, leap_cur);

  // quotient estimate of year / 400, then remainder with one correction
  assign prod    = PROD_W'(ld_year_r) * PROD_W'(RECIP_400);
  assign q_nxt   = prod[RECIP_SHIFT +: Q400_W];
  assign rem_raw = ld_year_r - YEAR_W'(YEAR_W'(q_r) * YEAR_W'(YEARS_400));
  assign rem     = (rem_raw >= YEAR_W'(YEARS_400)) ? Y400_W'(rem_raw - YEAR_W'(YEARS_400))
                                                   : Y400_W'(rem_raw);
  assign ld_len  = month_len(ld_month_r, leap_of(rem));

  // status towards the controller
  always_comb begin
    sts.cnt_zero = (cnt_r == '0);
    if (cmd.back)
      sts.at_bound = (day_r == DAY_FIRST) && (month_r == MONTH_JAN) && (year_r == YEAR_ZERO);
    else
      sts.at_bound = (day_r >= len_cur) && (month_r >= MONTH_DEC) && (year_r >= YEAR_LIM);
  end

  // capture and clamp the load fields
  always_comb begin
    ld_day_nxt   = ld_day_r;
    ld_month_nxt = ld_month_r;
    ld_year_nxt  = ld_year_r;
    if (cmd.capture) begin
      ld_day_nxt = in_day;
      if (in_month < MONTH_JAN)      ld_month_nxt = MONTH_JAN;
      else if (in_month > MONTH_DEC) ld_month_nxt = MONTH_DEC;
      else                           ld_month_nxt = in_month;
      ld_year_nxt = (in_year > YEAR_LIM) ? YEAR_LIM : in_year;
    end
  end

  // date update: load or one day forward or back
  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    y400_nxt  = y400_r;
    if (cmd.load_fix) begin
      if (ld_day_r < DAY_FIRST)  day_nxt = DAY_FIRST;
      else if (ld_day_r > ld_len) day_nxt = ld_len;
      else                        day_nxt = ld_day_r;
      month_nxt = ld_month_r;
      year_nxt  = ld_year_r;
      y400_nxt  = rem;
    end else if (cmd.step && !cmd.back) begin
      if (day_r < len_cur) begin
        day_nxt = day_r + DAY_FIRST;
      end else if (month_r < MONTH_DEC) begin
        month_nxt = month_r + MONTH_JAN;
        day_nxt   = DAY_FIRST;
      end else begin
        year_nxt  = year_r + YEAR_W'(1);
        y400_nxt  = (y400_r == Y400_TOP) ? '0 : y400_r + Y400_W'(1);
        month_nxt = MONTH_JAN;
        day_nxt   = DAY_FIRST;
      end
    end else if (cmd.step) begin
      if (day_r > DAY_FIRST) begin
        day_nxt = day_r - DAY_FIRST;
      end else if (month_r > MONTH_JAN) begin
        month_nxt = month_prev;
        day_nxt   = len_prev;
      end else begin
        year_nxt  = year_r - YEAR_W'(1);
        y400_nxt  = (y400_r == '0) ? Y400_TOP : y400_r - Y400_W'(1);
        month_nxt = MONTH_DEC;
        day_nxt   = DAY_31;
      end
    end
  end

  // day counter, error flag and result register
  always_comb begin
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    res_nxt = res_r;
    if (cmd.capture) begin
      cnt_nxt = in_count[CNT_W-1:0];
      err_nxt = 1'b0;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (cmd.set_err)  err_nxt = 1'b1;
    if (cmd.out_load) res_nxt = {err_r, leap_cur, year_r, month_r, day_r};
  end

  assign out_tdata = {(OUT_TDATA_W - RES_W)'(0), res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= DAY_FIRST;
      month_r <= MONTH_JAN;
      year_r  <= YEAR_RESET;
      y400_r  <= Y400_RESET;
    end else begin
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      y400_r  <= y400_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    cnt_r      <= cnt_nxt;
    ld_day_r   <= ld_day_nxt;
    ld_month_r <= ld_month_nxt;
    ld_year_r  <= ld_year_nxt;
    q_r        <= q_nxt;
    res_r      <= res_nxt;
  end

  a_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC) &&
    (day_r >= DAY_FIRST) && (day_r <= DAY_31))
    else $error("stored date out of range");

  a_y400_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (y400_r < YEARS_400))
    else $error("year modulo 400 tracker out of range");

endmodule

FILE: rtl/calendar_date_stepper_unit.sv
// Gregorian date counter holding day, month and year.
// Input channel in_*: in_tuser carries the operation (load, step forward, step
// back, anything else reports the date unchanged); in_tdata carries the date
// to load and the day count. Result channel out_*: one transaction per input
// transaction with the resulting date, its leap flag and the range error flag.
// A load runs from acceptance to out_tvalid in steps: month and year clamp on
// acceptance, quotient by 400 through a constant multiply, remainder and day
// clamp, result register.
// A step of N days runs in the stepping sequencer, which moves the date by one
// day per cycle and stops early when the year bound is reached.
// A no-op goes straight to the result register. One item is in work at a time;
// in_tready is high only between items, while a finished result may still wait
// in the output register. If the receiver stalls, the result holds on out_tdata
// and the next item is taken and worked but waits to finish until the register frees.
// Reset (rst_n low, synchronous) sets the date to January 1, 1900 and
// empties the result register.
module calendar_date_stepper_unit #(
  parameter int COUNT_BITS = 16,
  parameter int YEAR_MAX   = 9999
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // func[1:0]
  input  logic [cdate_pkg::FUNC_W-1:0]      in_tuser,
  // load_day[4:0], load_month[8:5], load_year[22:9], day_count[38:23]
  input  logic [cdate_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_day[4:0], out_month[8:5], out_year[22:9], leap_flag[23], range_error[24]
  output logic [cdate_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cdate_pkg::*;

  cdate_cmd_t cmd;
  cdate_sts_t sts;

  // controller
  cdate_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // datapath
  cdate_dp #(
    .COUNT_BITS (COUNT_BITS),
    .YEAR_MAX   (YEAR_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
